/* hw/rtl/salc_pkg.sv */
package salc_pkg;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [31:0] addr;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [31:0] read_data;
        logic        evicted;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

endpackage

/* hw/rtl/salc_ram.sv */
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hw/rtl/set_associative_lru_cache.sv */
// channel | dir | handshake          | word
// s_      | in  | s_valid / s_ready  | salc_pkg::req_t (op, addr, write_data)
// m_      | out | m_valid / m_ready  | salc_pkg::rsp_t (hit, read_data, evicted, totals)
//
// For each word the set row is read from the RAM, then compared, updated
// and written back, with the result loaded into the output register.
// After reset a clearing pass writes every row; s_ready stays low.
// A full output register that is not taken holds the lookup cycle.
// SETS and BLOCK_BYTES must be powers of two; the block itself does not check this.
module set_associative_lru_cache #(
    parameter int SETS        = 64,
    parameter int WAYS        = 8,
    parameter int BLOCK_BYTES = 64,
    parameter int ADDR_BITS   = 32,
    parameter int DATA_BITS   = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  salc_pkg::req_t  s_word,
    output logic            m_valid,
    input  logic            m_ready,
    output salc_pkg::rsp_t  m_word
);

    localparam int OFF_W   = $clog2(BLOCK_BYTES);
    localparam int SET_LOG = $clog2(SETS);
    localparam int SIDX_W  = (SETS > 1) ? SET_LOG : 1;
    localparam int TAG_RAW = ADDR_BITS - OFF_W - SET_LOG;
    localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
    localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef struct packed {
        logic                 valid;
        logic [TAG_W-1:0]     tag;
        logic [DATA_BITS-1:0] word;
        logic [WAY_W-1:0]     rank;
    } line_t;

    typedef line_t [WAYS-1:0] row_t;

    localparam int ROW_W = $bits(row_t);

    salc_pkg::state_t     state_reg, state_next;
    logic [SIDX_W-1:0]    clr_idx_reg, clr_idx_next;
    logic                 op_reg, op_next;
    logic [SIDX_W-1:0]    set_reg, set_next;
    logic [TAG_W-1:0]     tag_reg, tag_next;
    logic [DATA_BITS-1:0] wdata_reg, wdata_next;
    logic [31:0]          hit_cnt_reg, hit_cnt_next;
    logic [31:0]          miss_cnt_reg, miss_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    salc_pkg::rsp_t       out_reg, out_next;

    logic [ADDR_BITS-1:0] addr_ext;
    logic [ADDR_BITS-1:0] blk;
    logic                 accept;
    logic                 proceed;

    row_t                 row_rd, row_wr;
    logic [ROW_W-1:0]     ram_rdata;
    logic                 ram_we;
    logic [SIDX_W-1:0]    ram_waddr;

    logic [WAYS-1:0]      hit_vec;
    logic                 hit_any, inval_any;
    logic [WAY_W-1:0]     hit_way, inval_way, lru_way, target;
    logic [WAY_W-1:0]     target_rank;

    assign addr_ext = ADDR_BITS'(s_word.addr);
    assign blk      = addr_ext >> OFF_W;
    assign accept   = s_valid && s_ready;
    assign proceed  = (state_reg == salc_pkg::ST_LOOKUP) && (!out_valid_reg || m_ready);
    assign row_rd   = row_t'(ram_rdata);

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ROW_W'(row_wr)),
        .re    (accept),
        .raddr (set_next),
        .rdata (ram_rdata)
    );

    // way compare and victim choice
    always_comb begin
        hit_any   = 1'b0;
        inval_any = 1'b0;
        hit_way   = '0;
        inval_way = '0;
        lru_way   = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w] = row_rd[w].valid && (row_rd[w].tag == tag_reg);
        end
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!row_rd[w].valid) begin
                inval_any = 1'b1;
                inval_way = WAY_W'(w);
            end
            if (row_rd[w].rank == '0) begin
                lru_way = WAY_W'(w);
            end
        end
        priority if (hit_any) begin
            target = hit_way;
        end else if (inval_any) begin
            target = inval_way;
        end else begin
            target = lru_way;
        end
        target_rank = row_rd[target].rank;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= salc_pkg::ST_CLEAR;
            clr_idx_reg   <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg    <= op_next;
        set_reg   <= set_next;
        tag_reg   <= tag_next;
        wdata_reg <= wdata_next;
        out_reg   <= out_next;
    end

    always_comb begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        op_next        = op_reg;
        set_next       = set_reg;
        tag_next       = tag_reg;
        wdata_next     = wdata_reg;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        s_ready        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = set_reg;
        row_wr         = row_rd;

        unique case (state_reg)
            salc_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_idx_reg;
                for (int w = 0; w < WAYS; w++) begin
                    row_wr[w].valid = 1'b0;
                    row_wr[w].tag   = '0;
                    row_wr[w].word  = '0;
                    row_wr[w].rank  = WAY_W'(w);
                end
                clr_idx_next = clr_idx_reg + SIDX_W'(1);
                if (clr_idx_reg == SIDX_W'(SETS - 1)) begin
                    clr_idx_next = '0;
                    state_next   = salc_pkg::ST_IDLE;
                end
            end
            salc_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                op_next    = s_word.op;
                set_next   = SIDX_W'(blk & ADDR_BITS'(SETS - 1));
                tag_next   = TAG_W'(blk >> SET_LOG);
                wdata_next = DATA_BITS'(s_word.write_data);
                if (s_valid) begin
                    state_next = salc_pkg::ST_LOOKUP;
                end
            end
            salc_pkg::ST_LOOKUP: begin
                if (proceed) begin
                    state_next         = salc_pkg::ST_IDLE;
                    out_valid_next     = 1'b1;
                    out_next.hit       = hit_any;
                    out_next.evicted   = !hit_any && !inval_any && (op_reg == salc_pkg::OP_WRITE);
                    out_next.read_data = (hit_any && op_reg == salc_pkg::OP_READ)
                                         ? 32'(row_rd[hit_way].word) : 32'd0;
                    if (hit_any) begin
                        hit_cnt_next = (hit_cnt_reg == '1) ? hit_cnt_reg : hit_cnt_reg + 32'd1;
                    end else begin
                        miss_cnt_next = (miss_cnt_reg == '1) ? miss_cnt_reg
                                                             : miss_cnt_reg + 32'd1;
                    end
                    out_next.hit_total  = hit_cnt_next;
                    out_next.miss_total = miss_cnt_next;
                    if (hit_any || op_reg == salc_pkg::OP_WRITE) begin
                        ram_we = 1'b1;
                        for (int w = 0; w < WAYS; w++) begin
                            if (WAY_W'(w) == target) begin
                                row_wr[w].rank = WAY_W'(WAYS - 1);
                                if (op_reg == salc_pkg::OP_WRITE) begin
                                    row_wr[w].word  = wdata_reg;
                                    row_wr[w].tag   = tag_reg;
                                    row_wr[w].valid = 1'b1;
                                end
                            end else if (row_rd[w].rank > target_rank) begin
                                row_wr[w].rank = row_rd[w].rank - WAY_W'(1);
                            end
                        end
                    end
                end
            end
            default: begin
                state_next = salc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_word  = out_reg;

    a_accept_lookup: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == salc_pkg::ST_LOOKUP)
        else $error("accepted word did not start a lookup");

    a_one_hit_way: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == salc_pkg::ST_LOOKUP |-> $onehot0(hit_vec))
        else $error("tag matched in more than one way");

    a_hit_not_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_word.hit && m_word.evicted))
        else $error("hit and eviction in one result");

    a_miss_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_word.hit |-> m_word.read_data == 32'd0)
        else $error("read data on a miss");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == salc_pkg::ST_CLEAR |-> !s_ready)
        else $error("input taken during clearing pass");

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int N_SETS     = 64;
    localparam int N_WAYS     = 8;
    localparam int OFF_BITS   = 6;
    localparam int SET_BITS   = 6;
    localparam int TAG_BITS   = 32 - OFF_BITS - SET_BITS;
    localparam int N_RANDOM   = 800;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOT_SETS   = 4;
    localparam int HOT_TAGS   = 12;

    class cache_scoreboard;
        bit                  line_valid [N_SETS][N_WAYS];
        logic [TAG_BITS-1:0] line_tag   [N_SETS][N_WAYS];
        logic [31:0]         line_word  [N_SETS][N_WAYS];
        int unsigned         lru_rank   [N_SETS][N_WAYS];
        logic [31:0]         hit_count;
        logic [31:0]         miss_count;
        salc_pkg::rsp_t      expected_results[$];
        int unsigned         errors;

        function new();
            for (int s = 0; s < N_SETS; s++) begin
                for (int w = 0; w < N_WAYS; w++) begin
                    line_valid[s][w] = 1'b0;
                    lru_rank[s][w]   = w;
                end
            end
            hit_count  = '0;
            miss_count = '0;
            errors     = 0;
        endfunction

        function void make_mru(int s, int way);
            int unsigned r;
            r = lru_rank[s][way];
            for (int w = 0; w < N_WAYS; w++) begin
                if (lru_rank[s][w] > r) lru_rank[s][w]--;
            end
            lru_rank[s][way] = N_WAYS - 1;
        endfunction

        function void note_access(salc_pkg::req_t req);
            salc_pkg::rsp_t      rsp;
            int                  s;
            int                  found;
            int                  victim;
            logic [TAG_BITS-1:0] tag;
            rsp   = '0;
            s     = int'(req.addr[OFF_BITS +: SET_BITS]);
            tag   = req.addr[31 -: TAG_BITS];
            found = -1;
            for (int w = 0; w < N_WAYS; w++) begin
                if (found < 0 && line_valid[s][w] && line_tag[s][w] == tag) found = w;
            end
            if (found >= 0) begin
                rsp.hit = 1'b1;
                if (hit_count != 32'hFFFF_FFFF) hit_count++;
                if (req.op == salc_pkg::OP_READ) rsp.read_data = line_word[s][found];
                else line_word[s][found] = req.write_data;
                make_mru(s, found);
            end else begin
                if (miss_count != 32'hFFFF_FFFF) miss_count++;
                if (req.op == salc_pkg::OP_WRITE) begin
                    victim = -1;
                    for (int w = 0; w < N_WAYS; w++) begin
                        if (victim < 0 && !line_valid[s][w]) victim = w;
                    end
                    if (victim < 0) begin
                        for (int w = 0; w < N_WAYS; w++) begin
                            if (victim < 0 && lru_rank[s][w] == 0) victim = w;
                        end
                        rsp.evicted = 1'b1;
                    end
                    line_valid[s][victim] = 1'b1;
                    line_tag[s][victim]   = tag;
                    line_word[s][victim]  = req.write_data;
                    make_mru(s, victim);
                end
            end
            rsp.hit_total  = hit_count;
            rsp.miss_total = miss_count;
            expected_results.push_back(rsp);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(salc_pkg::rsp_t got);
            salc_pkg::rsp_t want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            compare_field("hit", 32'(want.hit), 32'(got.hit));
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("evicted", 32'(want.evicted), 32'(got.evicted));
            compare_field("hit_total", want.hit_total, got.hit_total);
            compare_field("miss_total", want.miss_total, got.miss_total);
        endfunction
    endclass

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    salc_pkg::req_t s_word  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    salc_pkg::rsp_t m_word;

    int              send_idle_pct = 0;
    int              recv_stall_pct = 0;
    int              idle_cycles = 0;
    cache_scoreboard sb = new();

    logic [SET_BITS-1:0] hot_set [HOT_SETS];
    logic [TAG_BITS-1:0] hot_tag [HOT_TAGS];

    always #2 aclk = ~aclk;

    set_associative_lru_cache i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_word);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_access(logic op, logic [31:0] addr, logic [31:0] data);
        salc_pkg::req_t req;
        req.op         = op;
        req.addr       = addr;
        req.write_data = data;
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_word  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_access(req);
    endtask

    initial begin
        logic                op;
        logic [31:0]         addr;
        int                  phase;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty cache, fill, hits on both ends of the address range
        send_access(salc_pkg::OP_READ, 32'h0000_0000, 32'h1234_5678);
        send_access(salc_pkg::OP_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
        send_access(salc_pkg::OP_READ, 32'h0000_003F, 32'h0000_0000);
        send_access(salc_pkg::OP_WRITE, 32'h0000_0020, 32'h0000_0000);
        send_access(salc_pkg::OP_READ, 32'h0000_0000, 32'hFFFF_FFFF);
        send_access(salc_pkg::OP_WRITE, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        send_access(salc_pkg::OP_READ, 32'hFFFF_FFC0, 32'h0000_0000);
        send_access(salc_pkg::OP_READ, 32'h0000_1000, 32'h0000_0000);
        // fill one set, refresh its oldest line, then force an eviction
        for (int t = 1; t <= N_WAYS; t++) begin
            send_access(salc_pkg::OP_WRITE, {TAG_BITS'(t), SET_BITS'(5), OFF_BITS'(t)},
                        $urandom);
        end
        send_access(salc_pkg::OP_READ, {TAG_BITS'(1), SET_BITS'(5), OFF_BITS'(0)}, $urandom);
        send_access(salc_pkg::OP_WRITE, {TAG_BITS'(9), SET_BITS'(5), OFF_BITS'(0)}, $urandom);
        send_access(salc_pkg::OP_READ, {TAG_BITS'(2), SET_BITS'(5), OFF_BITS'(0)}, $urandom);
        send_access(salc_pkg::OP_READ, {TAG_BITS'(1), SET_BITS'(5), OFF_BITS'(0)}, $urandom);
        send_access(salc_pkg::OP_WRITE, {TAG_BITS'(1), SET_BITS'(5), OFF_BITS'(9)},
                    32'h8000_0001);

        for (int i = 0; i < HOT_SETS; i++) hot_set[i] = SET_BITS'($urandom);
        for (int i = 0; i < HOT_TAGS; i++) hot_tag[i] = TAG_BITS'($urandom);
        hot_tag[0] = '0;
        hot_tag[1] = '1;

        for (int n = 0; n < N_RANDOM; n++) begin
            phase = n / (N_RANDOM / 4);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            op = 1'($urandom_range(1));
            if ($urandom_range(99) < 15) begin
                addr = $urandom;
            end else begin
                addr = {hot_tag[$urandom_range(HOT_TAGS - 1)],
                        hot_set[$urandom_range(HOT_SETS - 1)],
                        OFF_BITS'($urandom)};
            end
            send_access(op, addr, $urandom);
        end
        s_valid <= 1'b0;

        while (sb.expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
